[rtl/clwt_pkg.sv]
package clwt_pkg;

    localparam int DATA_W        = 64;
    localparam int FUNC_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 32;

    localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_STABLE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SNAPDROP = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RESTORE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_RANGE   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOOKUP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic latch;
        logic rd_key;
        logic fin_op;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic op_lookup;
        logic op_range;
        logic range_go;
        logic range_last;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/consensus_log_window_table_top.sv]
// a transaction is accepted in IDLE; its result is registered in EXEC, or in LOOKUP for
// term query and stable after one registered read of the entry ring; a range read does
// that read in EXEC and registers its first entry in EMIT, then streams one entry per
// cycle from the ring memory port unless stalled; only one transaction is in flight
// reset: i_rst_n synchronous, active low; clears window, snapshot and handshake state,
// the entry ring is not cleared and only entries inside the window are ever used
module consensus_log_window_table_top #(
    parameter int DEPTH = clwt_pkg::DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [clwt_pkg::FUNC_W-1:0]   i_func,
    input  logic [clwt_pkg::DATA_W-1:0]   i_key_index,
    input  logic [clwt_pkg::DATA_W-1:0]   i_range_end,
    input  logic [clwt_pkg::DATA_W-1:0]   i_entry_term,
    input  logic [clwt_pkg::DATA_W-1:0]   i_entry_payload,
    input  logic                          i_batch_first,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [clwt_pkg::STATUS_W-1:0] o_status,
    output logic [clwt_pkg::DATA_W-1:0]   o_out_index,
    output logic [clwt_pkg::DATA_W-1:0]   o_out_term,
    output logic [clwt_pkg::DATA_W-1:0]   o_out_payload,
    output logic                          o_first_valid,
    output logic [clwt_pkg::DATA_W-1:0]   o_first_index,
    output logic                          o_last_valid,
    output logic [clwt_pkg::DATA_W-1:0]   o_tail_index,
    output logic                          o_last_of_run
);

    clwt_pkg::t_dp_cmd    cmd;
    clwt_pkg::t_dp_status dp_status;

    clwt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    clwt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (dp_status),
        .i_func          (i_func),
        .i_key_index     (i_key_index),
        .i_range_end     (i_range_end),
        .i_entry_term    (i_entry_term),
        .i_entry_payload (i_entry_payload),
        .i_batch_first   (i_batch_first),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_res_status    (o_status),
        .o_out_index     (o_out_index),
        .o_out_term      (o_out_term),
        .o_out_payload   (o_out_payload),
        .o_first_valid   (o_first_valid),
        .o_first_index   (o_first_index),
        .o_last_valid    (o_last_valid),
        .o_tail_index    (o_tail_index),
        .o_last_of_run   (o_last_of_run)
    );

    // a range keeps streaming once a non-final entry is taken
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_run) |=> o_valid)
        else $error("range stream broke before its final entry");

    // no new transaction while a run is still being delivered
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |-> o_stall)
        else $error("input open during a range stream");

    // only range entries continue a run, and they always report ok
    a_error_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != clwt_pkg::ST_OK)) |-> o_last_of_run)
        else $error("error result not final");

endmodule

[rtl/clwt_ram.sv]
module clwt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/clwt_ctrl.sv]
module clwt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  clwt_pkg::t_dp_status i_status,
    output clwt_pkg::t_dp_cmd    o_cmd
);

    clwt_pkg::t_state r_state;
    clwt_pkg::t_state n_state;
    logic             range_go;

    assign range_go = i_status.op_range && i_status.range_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clwt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            clwt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = clwt_pkg::S_EXEC;
                end
            end
            clwt_pkg::S_EXEC: begin
                if (i_status.op_lookup) begin
                    n_state = clwt_pkg::S_LOOKUP;
                end else if (range_go) begin
                    n_state = clwt_pkg::S_EMIT;
                end else if (i_status.out_free) begin
                    n_state = clwt_pkg::S_IDLE;
                end
            end
            clwt_pkg::S_LOOKUP: begin
                if (i_status.out_free) begin
                    n_state = clwt_pkg::S_IDLE;
                end
            end
            clwt_pkg::S_EMIT: begin
                if (i_status.out_free && i_status.range_last) begin
                    n_state = clwt_pkg::S_IDLE;
                end
            end
            default: n_state = clwt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            clwt_pkg::S_IDLE: begin
                o_stall     = 1'b0;
                o_cmd.latch = i_valid;
            end
            clwt_pkg::S_EXEC: begin
                o_cmd.rd_key = i_status.op_lookup || range_go;
                o_cmd.fin_op = !i_status.op_lookup && !range_go && i_status.out_free;
            end
            clwt_pkg::S_LOOKUP: begin
                o_cmd.fin_op = i_status.out_free;
            end
            clwt_pkg::S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

[rtl/clwt_dp.sv]
module clwt_dp #(
    parameter int DEPTH = clwt_pkg::DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clwt_pkg::t_dp_cmd             i_cmd,
    output clwt_pkg::t_dp_status          o_status,
    input  logic [clwt_pkg::FUNC_W-1:0]   i_func,
    input  logic [clwt_pkg::DATA_W-1:0]   i_key_index,
    input  logic [clwt_pkg::DATA_W-1:0]   i_range_end,
    input  logic [clwt_pkg::DATA_W-1:0]   i_entry_term,
    input  logic [clwt_pkg::DATA_W-1:0]   i_entry_payload,
    input  logic                          i_batch_first,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [clwt_pkg::STATUS_W-1:0] o_res_status,
    output logic [clwt_pkg::DATA_W-1:0]   o_out_index,
    output logic [clwt_pkg::DATA_W-1:0]   o_out_term,
    output logic [clwt_pkg::DATA_W-1:0]   o_out_payload,
    output logic                          o_first_valid,
    output logic [clwt_pkg::DATA_W-1:0]   o_first_index,
    output logic                          o_last_valid,
    output logic [clwt_pkg::DATA_W-1:0]   o_tail_index,
    output logic                          o_last_of_run
);

    localparam int DW = clwt_pkg::DATA_W;
    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [SW-1:0] f_slot(input logic [SW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[SW-1:0];
    endfunction

    // latched transaction
    logic [clwt_pkg::FUNC_W-1:0] r_func;
    logic [DW-1:0]               r_key;
    logic [DW-1:0]               r_hi;
    logic [DW-1:0]               r_term;
    logic [DW-1:0]               r_payload;
    logic                        r_first;

    // window and snapshot
    logic [SW-1:0] r_head,   n_head;
    logic [CW-1:0] r_count,  n_count;
    logic [DW-1:0] r_base,   n_base;
    logic          r_snap_valid, n_snap_valid;
    logic [DW-1:0] r_snap_index, n_snap_index;
    logic [DW-1:0] r_snap_term,  n_snap_term;

    // range walk
    logic [CW-1:0] r_off;
    logic [CW-1:0] r_end;
    logic [DW-1:0] r_cur_index;

    // result register
    logic                          r_out_valid;
    logic [clwt_pkg::STATUS_W-1:0] r_out_status;
    logic [DW-1:0]                 r_out_index;
    logic [DW-1:0]                 r_out_term;
    logic [DW-1:0]                 r_out_payload;
    logic                          r_out_first_valid;
    logic [DW-1:0]                 r_out_first_index;
    logic                          r_out_last_valid;
    logic [DW-1:0]                 r_out_tail_index;
    logic                          r_out_last_of_run;

    logic [DW-1:0]                 key_off;
    logic [DW-1:0]                 span;
    logic [CW-1:0]                 d_low;
    logic [CW-1:0]                 k_adv;
    logic [CW-1:0]                 off_next;
    logic                          key_ge_base;
    logic                          d_in_win;
    logic                          rng_err;
    logic                          rng_empty;
    logic                          range_last;
    logic                          snap_hit;
    logic                          out_free;
    logic                          load;

    logic [2*DW-1:0]               rdata;
    logic [DW-1:0]                 rd_term;
    logic [DW-1:0]                 rd_payload;
    logic [SW-1:0]                 raddr;
    logic [SW-1:0]                 waddr;
    logic                          ram_we;

    logic [clwt_pkg::STATUS_W-1:0] app_status;
    logic [DW-1:0]                 app_base;
    logic [CW-1:0]                 app_count;

    logic [clwt_pkg::STATUS_W-1:0] res_status;
    logic [DW-1:0]                 res_term;
    logic                          nx_first_valid;
    logic [DW-1:0]                 nx_first_index;
    logic                          nx_last_valid;
    logic [DW-1:0]                 nx_tail_index;

    assign key_off     = r_key - r_base;
    assign span        = r_hi - r_base;
    assign d_low       = key_off[CW-1:0];
    assign k_adv       = d_low + CW'(1);
    assign off_next    = r_off + CW'(1);
    assign key_ge_base = r_key >= r_base;
    assign d_in_win    = key_ge_base && (key_off < DW'(r_count));
    assign rng_err     = (r_hi < r_key) || !key_ge_base || (span > DW'(r_count));
    assign rng_empty   = r_hi == r_key;
    assign range_last  = off_next == r_end;
    assign snap_hit    = r_snap_valid && (r_snap_index == r_key);
    assign out_free    = !r_out_valid || !i_stall;
    assign load        = i_cmd.fin_op || i_cmd.emit;

    assign o_status.op_lookup  = (r_func == clwt_pkg::FN_STABLE) || (r_func == clwt_pkg::FN_QUERY);
    assign o_status.op_range   = r_func == clwt_pkg::FN_RANGE;
    assign o_status.range_go   = !rng_err && !rng_empty;
    assign o_status.range_last = range_last;
    assign o_status.out_free   = out_free;

    assign rd_term    = rdata[2*DW-1:DW];
    assign rd_payload = rdata[DW-1:0];
    assign raddr      = f_slot(r_head, i_cmd.emit ? off_next : d_low);
    assign waddr      = f_slot(r_head, app_count);
    assign ram_we     = i_cmd.fin_op && (r_func == clwt_pkg::FN_APPEND)
                        && (app_status == clwt_pkg::ST_OK);

    clwt_ram #(
        .WIDTH (2 * DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata ({r_term, r_payload}),
        .i_re    (i_cmd.rd_key || i_cmd.emit),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // append placement
    always_comb begin
        app_status = clwt_pkg::ST_OK;
        app_base   = r_base;
        app_count  = r_count;
        if (key_ge_base && (key_off == DW'(r_count))) begin
            app_count = r_count;
        end else if (!r_first) begin
            app_status = clwt_pkg::ST_NOTFOUND;
        end else if (r_key <= r_base) begin
            app_base  = r_key;
            app_count = '0;
        end else if (key_off < DW'(r_count)) begin
            app_count = d_low;
        end else begin
            app_status = clwt_pkg::ST_NOTFOUND;
        end
        if ((app_status == clwt_pkg::ST_OK) && (app_count >= CW'(DEPTH))) begin
            app_status = clwt_pkg::ST_FULL;
        end
    end

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_base       = r_base;
        n_snap_valid = r_snap_valid;
        n_snap_index = r_snap_index;
        n_snap_term  = r_snap_term;
        res_status   = clwt_pkg::ST_NOTFOUND;
        res_term     = '0;
        if (i_cmd.fin_op) begin
            unique case (r_func)
                clwt_pkg::FN_APPEND: begin
                    res_status = app_status;
                    if (app_status == clwt_pkg::ST_OK) begin
                        n_base  = app_base;
                        n_count = app_count + CW'(1);
                    end
                end
                clwt_pkg::FN_STABLE: begin
                    if (d_in_win && (rd_term == r_term)) begin
                        n_head     = f_slot(r_head, k_adv);
                        n_count    = r_count - k_adv;
                        n_base     = r_key + DW'(1);
                        res_status = clwt_pkg::ST_OK;
                    end
                end
                clwt_pkg::FN_SNAPDROP: begin
                    if (snap_hit) begin
                        n_snap_valid = 1'b0;
                        res_status   = clwt_pkg::ST_OK;
                    end
                end
                clwt_pkg::FN_RESTORE: begin
                    n_base       = r_key + DW'(1);
                    n_count      = '0;
                    n_snap_valid = 1'b1;
                    n_snap_index = r_key;
                    n_snap_term  = r_term;
                    res_status   = clwt_pkg::ST_OK;
                end
                clwt_pkg::FN_QUERY: begin
                    if (key_ge_base && d_in_win) begin
                        res_status = clwt_pkg::ST_OK;
                        res_term   = rd_term;
                    end else if (!key_ge_base && snap_hit) begin
                        res_status = clwt_pkg::ST_OK;
                        res_term   = r_snap_term;
                    end
                end
                clwt_pkg::FN_RANGE: begin
                    res_status = rng_err ? clwt_pkg::ST_NOTFOUND : clwt_pkg::ST_EMPTY;
                end
                default: res_status = clwt_pkg::ST_NOTFOUND;
            endcase
        end
    end

    // first and last index after the transaction
    always_comb begin
        nx_first_valid = n_snap_valid;
        nx_first_index = n_snap_valid ? n_snap_index + DW'(1) : '0;
        if (n_count != '0) begin
            nx_last_valid = 1'b1;
            nx_tail_index = n_base + DW'(n_count - CW'(1));
        end else if (n_snap_valid) begin
            nx_last_valid = 1'b1;
            nx_tail_index = n_snap_index;
        end else begin
            nx_last_valid = 1'b0;
            nx_tail_index = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_count      <= '0;
            r_base       <= '0;
            r_snap_valid <= 1'b0;
            r_snap_index <= '0;
            r_snap_term  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_head       <= n_head;
            r_count      <= n_count;
            r_base       <= n_base;
            r_snap_valid <= n_snap_valid;
            r_snap_index <= n_snap_index;
            r_snap_term  <= n_snap_term;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func    <= i_func;
            r_key     <= i_key_index;
            r_hi      <= i_range_end;
            r_term    <= i_entry_term;
            r_payload <= i_entry_payload;
            r_first   <= i_batch_first;
        end
        if (i_cmd.rd_key) begin
            r_off       <= d_low;
            r_end       <= span[CW-1:0];
            r_cur_index <= r_key;
        end else if (i_cmd.emit) begin
            r_off       <= off_next;
            r_cur_index <= r_cur_index + DW'(1);
        end
        if (load) begin
            r_out_first_valid <= nx_first_valid;
            r_out_first_index <= nx_first_index;
            r_out_last_valid  <= nx_last_valid;
            r_out_tail_index  <= nx_tail_index;
            if (i_cmd.emit) begin
                r_out_status      <= clwt_pkg::ST_OK;
                r_out_index       <= r_cur_index;
                r_out_term        <= rd_term;
                r_out_payload     <= rd_payload;
                r_out_last_of_run <= range_last;
            end else begin
                r_out_status      <= res_status;
                r_out_index       <= '0;
                r_out_term        <= res_term;
                r_out_payload     <= '0;
                r_out_last_of_run <= 1'b1;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_res_status  = r_out_status;
    assign o_out_index   = r_out_index;
    assign o_out_term    = r_out_term;
    assign o_out_payload = r_out_payload;
    assign o_first_valid = r_out_first_valid;
    assign o_first_index = r_out_first_index;
    assign o_last_valid  = r_out_last_valid;
    assign o_tail_index  = r_out_tail_index;
    assign o_last_of_run = r_out_last_of_run;

endmodule

[dv/consensus_log_window_table_top_test.sv]
module consensus_log_window_table_top_test;
    import clwt_pkg::*;

    localparam int RING = DEPTH_DEFAULT;
    localparam logic [FUNC_W-1:0] FN_UNDEF_A = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNDEF_B = 3'd7;
    localparam logic [DATA_W-1:0] IDX_MAX = '1;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   out_index;
        logic [DATA_W-1:0]   out_term;
        logic [DATA_W-1:0]   out_payload;
        logic                first_valid;
        logic [DATA_W-1:0]   first_index;
        logic                last_valid;
        logic [DATA_W-1:0]   tail_index;
        logic                last_of_run;
    } t_log_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func;
    logic [DATA_W-1:0]   i_key_index;
    logic [DATA_W-1:0]   i_range_end;
    logic [DATA_W-1:0]   i_entry_term;
    logic [DATA_W-1:0]   i_entry_payload;
    logic                i_batch_first;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_out_index;
    logic [DATA_W-1:0]   o_out_term;
    logic [DATA_W-1:0]   o_out_payload;
    logic                o_first_valid;
    logic [DATA_W-1:0]   o_first_index;
    logic                o_last_valid;
    logic [DATA_W-1:0]   o_tail_index;
    logic                o_last_of_run;

    // shadow copy of the log window and snapshot
    logic [DATA_W-1:0] m_term [RING];
    logic [DATA_W-1:0] m_pay [RING];
    int                m_head = 0;
    int                m_count = 0;
    logic [DATA_W-1:0] m_base = '0;
    bit                m_snap_v = 1'b0;
    logic [DATA_W-1:0] m_snap_idx = '0;
    logic [DATA_W-1:0] m_snap_term = '0;

    t_log_result expected_results[$];
    int          mismatch_count = 0;
    bit          send_gaps_on = 1'b1;
    bit          stall_bursts_on = 1'b1;
    int          stall_left = 0;

    consensus_log_window_table_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_key_index    (i_key_index),
        .i_range_end    (i_range_end),
        .i_entry_term   (i_entry_term),
        .i_entry_payload(i_entry_payload),
        .i_batch_first  (i_batch_first),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_out_index    (o_out_index),
        .o_out_term     (o_out_term),
        .o_out_payload  (o_out_payload),
        .o_first_valid  (o_first_valid),
        .o_first_index  (o_first_index),
        .o_last_valid   (o_last_valid),
        .o_tail_index   (o_tail_index),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int ring_slot(input logic [DATA_W-1:0] off);
        return (m_head + int'(off % RING)) % RING;
    endfunction

    function automatic bit find_term(input logic [DATA_W-1:0] idx,
                                     output logic [DATA_W-1:0] t);
        t = '0;
        if (idx < m_base) begin
            if (m_snap_v && m_snap_idx == idx) begin
                t = m_snap_term;
                return 1'b1;
            end
            return 1'b0;
        end
        if (idx - m_base < 64'(m_count)) begin
            t = m_term[ring_slot(idx - m_base)];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_result(input logic [STATUS_W-1:0] st, input logic [DATA_W-1:0] idx,
                               input logic [DATA_W-1:0] trm, input logic [DATA_W-1:0] pay,
                               input bit last);
        t_log_result r;
        r.status      = st;
        r.out_index   = idx;
        r.out_term    = trm;
        r.out_payload = pay;
        r.first_valid = m_snap_v;
        r.first_index = m_snap_v ? m_snap_idx + 64'd1 : '0;
        if (m_count > 0) begin
            r.last_valid = 1'b1;
            r.tail_index = m_base + 64'(m_count) - 64'd1;
        end else if (m_snap_v) begin
            r.last_valid = 1'b1;
            r.tail_index = m_snap_idx;
        end else begin
            r.last_valid = 1'b0;
            r.tail_index = '0;
        end
        r.last_of_run = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_log_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] key,
                                  input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] trm,
                                  input logic [DATA_W-1:0] pay, input bit first);
        logic [STATUS_W-1:0] st;
        logic [DATA_W-1:0]   found;
        logic [DATA_W-1:0]   d;
        logic [DATA_W-1:0]   nb;
        logic [DATA_W-1:0]   k;
        logic [DATA_W-1:0]   n;
        logic [DATA_W-1:0]   cnt64;
        int                  nc;
        int                  s;
        st = ST_NOTFOUND;
        found = '0;
        cnt64 = 64'(m_count);
        case (fn)
            FN_APPEND: begin
                d = key - m_base;
                nb = m_base;
                nc = m_count;
                st = ST_OK;
                if (key >= m_base && d == cnt64) begin
                    // plain append at the window end
                    st = ST_OK;
                end else if (!first) begin
                    st = ST_NOTFOUND;
                end else if (key <= m_base) begin
                    nb = key;
                    nc = 0;
                end else if (d < cnt64) begin
                    nc = int'(d);
                end else begin
                    st = ST_NOTFOUND;
                end
                if (st == ST_OK && nc >= RING)
                    st = ST_FULL;
                if (st == ST_OK) begin
                    m_base = nb;
                    m_count = nc;
                    s = ring_slot(64'(m_count));
                    m_term[s] = trm;
                    m_pay[s] = pay;
                    m_count++;
                end
            end
            FN_STABLE: begin
                if (find_term(key, found) && found == trm && key >= m_base) begin
                    k = key - m_base + 64'd1;
                    m_head = ring_slot(k);
                    m_count -= int'(k);
                    m_base = key + 64'd1;
                    st = ST_OK;
                end
                found = '0;
            end
            FN_SNAPDROP: begin
                if (m_snap_v && m_snap_idx == key) begin
                    m_snap_v = 1'b0;
                    st = ST_OK;
                end
            end
            FN_RESTORE: begin
                m_base = key + 64'd1;
                m_count = 0;
                m_snap_v = 1'b1;
                m_snap_idx = key;
                m_snap_term = trm;
                st = ST_OK;
            end
            FN_QUERY: begin
                if (find_term(key, found))
                    st = ST_OK;
                else
                    found = '0;
            end
            FN_RANGE: begin
                if (hi < key || key < m_base || hi - m_base > cnt64) begin
                    st = ST_NOTFOUND;
                end else if (hi == key) begin
                    st = ST_EMPTY;
                end else begin
                    n = hi - key;
                    for (int i = 0; i < int'(n); i++) begin
                        s = ring_slot(key - m_base + 64'(i));
                        push_result(ST_OK, key + 64'(i), m_term[s], m_pay[s], i == int'(n) - 1);
                    end
                    return;
                end
            end
            default: st = ST_NOTFOUND;
        endcase
        push_result(st, '0, found, '0, 1'b1);
    endtask

    // drives one transaction and waits until it is taken
    task automatic send_log_op(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] key,
                               input logic [DATA_W-1:0] hi, input logic [DATA_W-1:0] trm,
                               input logic [DATA_W-1:0] pay, input bit first);
        if (send_gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_func <= fn;
        i_key_index <= key;
        i_range_end <= hi;
        i_entry_term <= trm;
        i_entry_payload <= pay;
        i_batch_first <= first;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_log_op(fn, key, hi, trm, pay, first);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_log_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction, status %0d", o_status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("out_index", want.out_index, o_out_index);
                check_field("out_term", want.out_term, o_out_term);
                check_field("out_payload", want.out_payload, o_out_payload);
                check_field("first_valid", 64'(want.first_valid), 64'(o_first_valid));
                check_field("first_index", want.first_index, o_first_index);
                check_field("last_valid", 64'(want.last_valid), 64'(o_last_valid));
                check_field("tail_index", want.tail_index, o_tail_index);
                check_field("last_of_run", 64'(want.last_of_run), 64'(o_last_of_run));
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (stall_bursts_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 6);
        i_stall <= (stall_left > 0);
    end

    task automatic test_empty_window();
        send_log_op(FN_QUERY, 64'd0, rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_RANGE, 64'd0, 64'd0, rand64(), rand64(), 1'b0);
        send_log_op(FN_SNAPDROP, 64'd0, rand64(), rand64(), rand64(), 1'b1);
        // batch start beyond the window end
        send_log_op(FN_APPEND, 64'd5, rand64(), 64'd1, rand64(), 1'b1);
    endtask

    task automatic test_batch_appends();
        send_log_op(FN_RESTORE, 64'd9, rand64(), 64'd3, rand64(), 1'b0);
        send_log_op(FN_APPEND, 64'd10, rand64(), 64'd3, IDX_MAX, 1'b0);
        send_log_op(FN_APPEND, 64'd11, rand64(), 64'd4, 64'd0, 1'b0);
        send_log_op(FN_APPEND, 64'd12, rand64(), 64'd4, rand64(), 1'b0);
        // continuation off the end
        send_log_op(FN_APPEND, 64'd14, rand64(), 64'd4, rand64(), 1'b0);
        // batch start inside the window truncates
        send_log_op(FN_APPEND, 64'd12, rand64(), 64'd5, rand64(), 1'b1);
    endtask

    task automatic test_term_lookups();
        send_log_op(FN_QUERY, 64'd9, rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_QUERY, 64'd11, rand64(), rand64(), rand64(), 1'b1);
        send_log_op(FN_QUERY, 64'd13, rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_QUERY, 64'd8, rand64(), rand64(), rand64(), 1'b0);
    endtask

    task automatic test_range_reads();
        send_log_op(FN_RANGE, 64'd10, 64'd13, rand64(), rand64(), 1'b0);
        send_log_op(FN_RANGE, 64'd11, 64'd11, rand64(), rand64(), 1'b0);
        send_log_op(FN_RANGE, 64'd12, 64'd10, rand64(), rand64(), 1'b0);
        send_log_op(FN_RANGE, 64'd9, 64'd11, rand64(), rand64(), 1'b0);
        send_log_op(FN_RANGE, 64'd10, 64'd14, rand64(), rand64(), 1'b1);
    endtask

    task automatic test_stable_marks();
        // snapshot term matches but the index is below base
        send_log_op(FN_STABLE, 64'd9, rand64(), 64'd3, rand64(), 1'b0);
        send_log_op(FN_STABLE, 64'd11, rand64(), 64'd99, rand64(), 1'b0);
        send_log_op(FN_STABLE, 64'd11, rand64(), 64'd4, rand64(), 1'b0);
        send_log_op(FN_SNAPDROP, 64'd8, rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_SNAPDROP, 64'd9, rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_SNAPDROP, 64'd9, rand64(), rand64(), rand64(), 1'b0);
    endtask

    task automatic test_restart_and_undefined();
        send_log_op(FN_RESTORE, 64'd20, rand64(), 64'd7, rand64(), 1'b0);
        // batch start below base restarts the window
        send_log_op(FN_APPEND, 64'd15, rand64(), 64'd8, rand64(), 1'b1);
        // snapshot index above the entries is not found
        send_log_op(FN_QUERY, 64'd20, rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_UNDEF_A, rand64(), rand64(), rand64(), rand64(), 1'b1);
        send_log_op(FN_UNDEF_B, rand64(), rand64(), rand64(), rand64(), 1'b0);
    endtask

    task automatic test_index_wrap();
        send_log_op(FN_RESTORE, IDX_MAX, rand64(), IDX_MAX, rand64(), 1'b1);
        send_log_op(FN_RESTORE, IDX_MAX - 64'd2, rand64(), IDX_MAX, rand64(), 1'b0);
        send_log_op(FN_APPEND, IDX_MAX - 64'd1, rand64(), IDX_MAX, IDX_MAX, 1'b0);
        send_log_op(FN_APPEND, IDX_MAX, rand64(), 64'd0, rand64(), 1'b0);
        send_log_op(FN_APPEND, 64'd0, rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_RANGE, IDX_MAX - 64'd1, IDX_MAX, rand64(), rand64(), 1'b0);
        send_log_op(FN_QUERY, 64'd0, IDX_MAX, rand64(), rand64(), 1'b0);
    endtask

    task automatic test_ring_full();
        send_log_op(FN_RESTORE, 64'd100, rand64(), rand64(), rand64(), 1'b0);
        for (int i = 0; i < RING; i++)
            send_log_op(FN_APPEND, 64'd101 + 64'(i), rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_APPEND, 64'd101 + 64'(RING), rand64(), rand64(), rand64(), 1'b1);
        send_log_op(FN_APPEND, 64'd101 + 64'(RING), rand64(), rand64(), rand64(), 1'b0);
        send_log_op(FN_RANGE, 64'd101, 64'd101 + 64'(RING), rand64(), rand64(), 1'b0);
        send_log_op(FN_STABLE, 64'd100 + 64'(RING), rand64(),
                    m_term[ring_slot(64'(RING - 1))], rand64(), 1'b0);
    endtask

    // picks a transaction that mostly lands inside or next to the current window
    task automatic send_random_op();
        int                pick;
        int                off;
        int                span;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] trm;
        pick = $urandom_range(0, 99);
        if (pick < 34) begin
            send_log_op(FN_APPEND, m_base + 64'(m_count), rand64(), rand64(), rand64(), 1'b0);
        end else if (pick < 44) begin
            key = m_base - 64'd2 + 64'($urandom_range(0, m_count + 3));
            send_log_op(FN_APPEND, key, rand64(), rand64(), rand64(), 1'b1);
        end else if (pick < 54) begin
            if (m_count > 0 && $urandom_range(0, 9) != 0) begin
                off = $urandom_range(0, m_count - 1);
                key = m_base + 64'(off);
                trm = m_term[ring_slot(64'(off))];
            end else begin
                key = m_base - 64'd1 + 64'($urandom_range(0, m_count + 1));
                trm = $urandom_range(0, 1) ? m_snap_term : rand64();
            end
            send_log_op(FN_STABLE, key, rand64(), trm, rand64(), 1'($urandom_range(0, 1)));
        end else if (pick < 62) begin
            if ($urandom_range(0, 3) == 0)
                key = m_snap_idx;
            else
                key = m_base - 64'd2 + 64'($urandom_range(0, m_count + 3));
            send_log_op(FN_QUERY, key, rand64(), rand64(), rand64(), 1'($urandom_range(0, 1)));
        end else if (pick < 74) begin
            off = $urandom_range(0, m_count);
            span = m_count - off;
            if (span > 8)
                span = 8;
            key = m_base + 64'(off);
            hi = key + 64'($urandom_range(0, span));
            case ($urandom_range(0, 7))
                0: hi = hi + 64'd1;
                1: key = key - 64'd1;
                default: ;
            endcase
            send_log_op(FN_RANGE, key, hi, rand64(), rand64(), 1'($urandom_range(0, 1)));
        end else if (pick < 78) begin
            key = $urandom_range(0, 3) != 0 ? m_snap_idx : rand64();
            send_log_op(FN_SNAPDROP, key, rand64(), rand64(), rand64(),
                        1'($urandom_range(0, 1)));
        end else if (pick < 82) begin
            key = $urandom_range(0, 1) ? rand64() : m_base + 64'($urandom_range(0, 40));
            send_log_op(FN_RESTORE, key, rand64(), rand64(), rand64(),
                        1'($urandom_range(0, 1)));
        end else begin
            send_log_op(FN_UNDEF_A & 3'($urandom_range(0, 7)), rand64(), rand64(), rand64(),
                        rand64(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
            send_random_op();
    endtask

    // holds off the sender until all outstanding results are in, then resumes random traffic
    task automatic test_drain_pause();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        test_random_traffic(20);
    endtask

    task automatic test_steady_stream(input int count);
        send_gaps_on = 1'b0;
        stall_bursts_on = 1'b0;
        test_random_traffic(count);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = '0;
        i_key_index = '0;
        i_range_end = '0;
        i_entry_term = '0;
        i_entry_payload = '0;
        i_batch_first = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_empty_window();
        test_batch_appends();
        test_term_lookups();
        test_range_reads();
        test_stable_marks();
        test_restart_and_undefined();
        test_index_wrap();
        test_ring_full();
        test_random_traffic(150);
        test_drain_pause();
        test_steady_stream(60);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("PASS consensus_log_window_table_top");
        else
            $display("FAIL consensus_log_window_table_top");
        $finish;
    end

    initial begin
        #5000000;
        $display("FAIL consensus_log_window_table_top");
        $finish;
    end

endmodule
